/* hw/rtl/wpfd_pkg.sv */
// ----------------------------------------------------------------------------
// wpfd_pkg: shared types and constants of the wire field decoder
// Field kinds, error codes, the transaction payload structs and the
// sign helpers used by the decode step.
// ----------------------------------------------------------------------------
package wpfd_pkg;

  localparam int MAX_VARINT_BYTES = 10;

  // field kinds, as carried on the action field
  localparam logic [3:0] KIND_INT8     = 4'd0;
  localparam logic [3:0] KIND_INT16    = 4'd1;
  localparam logic [3:0] KIND_INT32    = 4'd2;
  localparam logic [3:0] KIND_INT64    = 4'd3;
  localparam logic [3:0] KIND_UINT32   = 4'd4;
  localparam logic [3:0] KIND_UVARINT  = 4'd5;
  localparam logic [3:0] KIND_VARINT   = 4'd6;
  localparam logic [3:0] KIND_UVARLONG = 4'd7;
  localparam logic [3:0] KIND_VARLONG  = 4'd8;
  localparam logic [3:0] KIND_CSTRING  = 4'd9;
  localparam logic [3:0] KIND_NSTRING  = 4'd10;
  localparam logic [3:0] KIND_TAGGED   = 4'd11;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_CLEN_ZERO = 2'd1;
  localparam logic [1:0] ERR_TAG_SET   = 2'd2;
  localparam logic [1:0] ERR_VAR_LONG  = 2'd3;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [7:0] DATA_MASK = 8'h7F;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam int         VAR_GROUP = 7;

  typedef struct packed {
    logic [7:0] in_byte;
    logic [3:0] action;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic        is_payload;
    logic        last;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic    has_result;
    result_t result;
  } step_t;

  function automatic logic [63:0] sext32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  function automatic logic [63:0] unzig(input logic [63:0] n);
    return n[0] ? ~(n >> 1) : (n >> 1);
  endfunction

endpackage

/* hw/rtl/wpfd_if.sv */
// ----------------------------------------------------------------------------
// wpfd_if: stream channels of the wire field decoder
// Byte channel into the decoder and result channel out of it.
// ----------------------------------------------------------------------------
interface wpfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic [3:0] action;

  modport source (output valid, output in_byte, output action, input ready);
  modport sink   (input valid, input in_byte, input action, output ready);
endinterface

interface wpfd_field_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        is_payload;
  logic        last;
  logic [1:0]  error_code;

  modport source (output valid, output value, output is_payload, output last,
                  output error_code, input ready);
  modport sink   (input valid, input value, input is_payload, input last,
                  input error_code, output ready);
endinterface

/* hw/rtl/wpfd_in_stage.sv */
// ----------------------------------------------------------------------------
// wpfd_in_stage: input register
// Holds one byte transaction until the decode step consumes it.
// ----------------------------------------------------------------------------
module wpfd_in_stage (
  input  logic            clk,
  input  logic            rst,
  wpfd_byte_if.sink       bytes,
  input  logic            advance,
  output logic            item_valid,
  output wpfd_pkg::item_t item
);
  import wpfd_pkg::*;

  assign bytes.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (bytes.ready) begin
      item_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      item.in_byte <= bytes.in_byte;
      item.action  <= bytes.action;
    end
  end

endmodule

/* hw/rtl/wpfd_core.sv */
// ----------------------------------------------------------------------------
// wpfd_core: field state and decode step
// Updates the field state once per consumed byte and forms the result.
// ----------------------------------------------------------------------------
module wpfd_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  wpfd_pkg::item_t item,
  output wpfd_pkg::step_t step
);
  import wpfd_pkg::*;

  logic        active, active_next;
  logic [3:0]  kind, kind_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  idx, idx_next;
  logic [31:0] remaining, remaining_next;
  logic        in_payload, in_payload_next;

  always_comb begin
    logic [3:0]  ekind;
    logic [63:0] eacc;
    logic [3:0]  eidx;
    logic [31:0] erem;
    logic        epay;
    logic [7:0]  b;
    logic [63:0] acc_sh;
    logic [63:0] acc_or;
    logic [3:0]  idx1;
    logic [6:0]  sh;
    logic [3:0]  fsize;
    logic [31:0] len;
    logic [31:0] rem_dec;
    logic        go_idle;

    b       = item.in_byte;
    ekind   = active ? kind : item.action;
    eacc    = active ? acc : 64'd0;
    eidx    = active ? idx : 4'd0;
    erem    = active ? remaining : 32'd0;
    epay    = active && in_payload;
    acc_sh  = {eacc[55:0], b};
    idx1    = eidx + 4'd1;
    sh      = 7'(eidx) * 7'(VAR_GROUP);
    acc_or  = eacc | (64'(b & DATA_MASK) << sh);
    rem_dec = erem - 32'd1;
    len     = 32'd0;
    go_idle = 1'b0;

    unique case (ekind)
      KIND_INT8:   fsize = 4'd1;
      KIND_INT16:  fsize = 4'd2;
      KIND_INT64:  fsize = 4'd8;
      default:     fsize = 4'd4;
    endcase

    active_next     = 1'b1;
    kind_next       = ekind;
    acc_next        = eacc;
    idx_next        = eidx;
    remaining_next  = erem;
    in_payload_next = epay;
    step            = '0;

    if (!active && item.action > KIND_TAGGED) begin
      // unused kind while idle: byte dropped, state untouched
      active_next = 1'b0;
      kind_next   = kind;
    end else if (epay) begin
      step.has_result        = 1'b1;
      step.result.value      = 64'(b);
      step.result.is_payload = 1'b1;
      remaining_next         = rem_dec;
      if (rem_dec == 32'd0) begin
        step.result.last = 1'b1;
        go_idle          = 1'b1;
      end
    end else if (ekind <= KIND_UINT32) begin
      acc_next = acc_sh;
      idx_next = idx1;
      if (idx1 >= fsize) begin
        step.has_result  = 1'b1;
        step.result.last = 1'b1;
        go_idle          = 1'b1;
        unique case (ekind)
          KIND_INT8:   step.result.value = {{56{acc_sh[7]}}, acc_sh[7:0]};
          KIND_INT16:  step.result.value = {{48{acc_sh[15]}}, acc_sh[15:0]};
          KIND_INT32:  step.result.value = sext32(acc_sh);
          KIND_UINT32: step.result.value = {32'd0, acc_sh[31:0]};
          default:     step.result.value = acc_sh;
        endcase
      end
    end else if (ekind <= KIND_CSTRING) begin
      acc_next = acc_or;
      idx_next = idx1;
      if ((b & CONT_BIT) != ZERO_BYTE) begin
        if (32'(idx1) >= 32'(MAX_VARINT_BYTES)) begin
          step.has_result        = 1'b1;
          step.result.last       = 1'b1;
          step.result.error_code = ERR_VAR_LONG;
          go_idle                = 1'b1;
        end
      end else begin
        unique case (ekind)
          KIND_UVARINT: begin
            step.has_result   = 1'b1;
            step.result.value = {32'd0, acc_or[31:0]};
          end
          KIND_VARINT: begin
            step.has_result   = 1'b1;
            step.result.value = sext32(unzig(acc_or));
          end
          KIND_UVARLONG: begin
            step.has_result   = 1'b1;
            step.result.value = acc_or;
          end
          KIND_VARLONG: begin
            step.has_result   = 1'b1;
            step.result.value = unzig(acc_or);
          end
          default: begin
            len      = acc_or[31:0];
            acc_next = 64'd0;
            idx_next = 4'd0;
            if (len == 32'd0) begin
              step.has_result        = 1'b1;
              step.result.error_code = ERR_CLEN_ZERO;
            end else if (len == 32'd1) begin
              step.has_result = 1'b1;    // empty string
            end else begin
              remaining_next  = len - 32'd1;
              in_payload_next = 1'b1;
            end
          end
        endcase
        if (step.has_result) begin
          step.result.last = 1'b1;
          go_idle          = 1'b1;
        end
      end
    end else if (ekind == KIND_NSTRING) begin
      acc_next = acc_sh;
      idx_next = idx1;
      if (idx1 >= 4'd2) begin
        acc_next = 64'd0;
        idx_next = 4'd0;
        len      = acc_sh[15] ? 32'd0 : 32'(acc_sh[15:0]);
        if (len == 32'd0) begin
          step.has_result  = 1'b1;
          step.result.last = 1'b1;
          go_idle          = 1'b1;
        end else begin
          remaining_next  = len;
          in_payload_next = 1'b1;
        end
      end
    end else if (ekind == KIND_TAGGED) begin
      step.has_result  = 1'b1;
      step.result.last = 1'b1;
      go_idle          = 1'b1;
      if (b != ZERO_BYTE) begin
        step.result.value      = 64'(b);
        step.result.error_code = ERR_TAG_SET;
      end
    end else begin
      go_idle = 1'b1;
    end

    if (go_idle) begin
      active_next     = 1'b0;
      acc_next        = 64'd0;
      idx_next        = 4'd0;
      remaining_next  = 32'd0;
      in_payload_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      kind       <= KIND_INT8;
      acc        <= 64'd0;
      idx        <= 4'd0;
      remaining  <= 32'd0;
      in_payload <= 1'b0;
    end else if (advance) begin
      active     <= active_next;
      kind       <= kind_next;
      acc        <= acc_next;
      idx        <= idx_next;
      remaining  <= remaining_next;
      in_payload <= in_payload_next;
    end
  end

endmodule

/* hw/rtl/wpfd_out_stage.sv */
// ----------------------------------------------------------------------------
// wpfd_out_stage: result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module wpfd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wpfd_pkg::result_t result,
  output logic              free,
  wpfd_field_if.source      fields
);
  import wpfd_pkg::*;

  result_t held;

  assign free = !fields.valid || fields.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fields.valid <= 1'b0;
    end else if (free) begin
      fields.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign fields.value      = held.value;
  assign fields.is_payload = held.is_payload;
  assign fields.last       = held.last;
  assign fields.error_code = held.error_code;

endmodule

/* hw/rtl/wire_primitive_field_decoder.sv */
// ----------------------------------------------------------------------------
// wire_primitive_field_decoder: primitive wire field decoder
// Decodes big-endian integers, LEB128 varints (plain and zigzag), compact
// and nullable strings and the tagged-field byte from a byte stream.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                 per transaction
//   -------  ---  --------------------------------------  -------------------
//   bytes    in   in_byte[7:0], action[3:0]               one wire byte
//   fields   out  value[63:0], is_payload, last,          zero or one result
//                 error_code[1:0]                         per byte
//
// One byte per clock sustained while results are taken. A byte is held in
// the input register, is decoded in the cycle it leaves it and its result
// shows on the next cycle from the result register.
// Synchronous reset returns to idle with both registers empty; no clearing.
// A stalled result holds the result register; the input register then
// holds one more byte and further bytes back up through bytes.ready.
//
module wire_primitive_field_decoder (
  input  logic         clk,
  input  logic         rst,
  wpfd_byte_if.sink    bytes,
  wpfd_field_if.source fields
);
  import wpfd_pkg::*;

  logic  item_valid;
  item_t item;
  step_t step;
  logic  out_free;
  logic  advance;

  // a byte moves on only when the result register can take whatever it
  // produces, so bytes that make no result also wait behind a stall
  assign advance = item_valid && out_free;

  wpfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // field state and the whole decode step for one byte
  wpfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .step    (step)
  );

  wpfd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && step.has_result),
    .result (step.result),
    .free   (out_free),
    .fields (fields)
  );

endmodule

/* hw/rtl/wpfd_checker.sv */
// ----------------------------------------------------------------------------
// wpfd_checker: port-level checks of the field decoder
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module wpfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value,
  input logic        is_payload,
  input logic        last,
  input logic [1:0]  error_code
);
  import wpfd_pkg::*;

  // a stalled result transaction keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(last)
      && $stable(is_payload) && $stable(error_code))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // every error ends its field
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_OK |-> last && !is_payload)
    else $error("error result not final");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code == ERR_CLEN_ZERO || error_code == ERR_VAR_LONG)
      |-> value == 64'd0)
    else $error("length error with nonzero value");

  a_payload_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (is_payload || error_code == ERR_TAG_SET) |-> value[63:8] == 56'd0)
    else $error("byte result wider than a byte");

endmodule

bind wire_primitive_field_decoder wpfd_checker u_wpfd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (fields.valid),
  .out_ready  (fields.ready),
  .value      (fields.value),
  .is_payload (fields.is_payload),
  .last       (fields.last),
  .error_code (fields.error_code)
);

/* tb/sv/wire_primitive_field_decoder_test.sv */
// ----------------------------------------------------------------------------
// wire_primitive_field_decoder_test: self-checking bench for the field decoder
// Streams wire bytes that form whole fields: fixed-width integers, LEB128
// varints, compact and nullable strings and tagged bytes, plus ignored and
// malformed input. A predictor in the bench tracks the field state per byte
// and queues the expected results. A checker compares every result
// transaction against the oldest entry. Directed fields come first, then
// random fields under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module wire_primitive_field_decoder_test;
  import wpfd_pkg::*;

  // no accepted transaction on either side for this long means a hang
  localparam int STALL_LIMIT = 4000;
  // random wire bytes per idling mix
  localparam int PHASE_BYTES = 380;

  logic clk = 1'b0;
  logic rst;

  wpfd_byte_if  byte_ch ();
  wpfd_field_if field_ch ();

  wire_primitive_field_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (byte_ch),
    .fields (field_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idling mix, in percent of cycles
  int send_idle_pct;
  int recv_stall_pct;

  int bytes_sent;
  int mismatch_count;
  int quiet_cycles;

  // results the decoder still owes us, oldest first
  result_t expected_fields[$];

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the decoder's field state machine.
  // --------------------------------------------------------------------------
  logic        fld_active = 1'b0;
  logic [3:0]  fld_kind   = KIND_INT8;
  logic [63:0] acc        = '0;
  logic [3:0]  byte_idx   = '0;
  logic [31:0] pay_left   = '0;
  logic        in_pay     = 1'b0;

  function automatic void go_idle();
    fld_active = 1'b0;
    in_pay     = 1'b0;
    acc        = '0;
    byte_idx   = '0;
    pay_left   = '0;
  endfunction

  function automatic void expect_field(input logic [63:0] v, input logic pay,
                                       input logic lst, input logic [1:0] err);
    result_t r;
    r.value      = v;
    r.is_payload = pay;
    r.last       = lst;
    r.error_code = err;
    expected_fields.push_back(r);
  endfunction

  // zigzag: even codes are non-negative, odd codes negative
  function automatic logic [63:0] zigzag_decode(input logic [63:0] z);
    return (z >> 1) ^ {64{z[0]}};
  endfunction

  // empty string closes the field at once, else count payload bytes
  function automatic void open_string(input logic [31:0] len);
    if (len == 0) begin
      go_idle();
      expect_field('0, 1'b0, 1'b1, ERR_OK);
    end else begin
      pay_left = len;
      in_pay   = 1'b1;
    end
  endfunction

  // Advance the predicted state by one accepted wire byte.
  function automatic void decode_byte(input logic [7:0] b, input logic [3:0] act);
    logic [63:0] n;
    logic [31:0] len;
    int          need;
    int          sh;
    // field type is only sampled on the first byte; unused codes are dropped
    if (!fld_active) begin
      if (act > KIND_TAGGED)
        return;
      fld_kind   = act;
      fld_active = 1'b1;
      acc        = '0;
      byte_idx   = '0;
      in_pay     = 1'b0;
      pay_left   = '0;
    end

    if (in_pay) begin
      pay_left = pay_left - 32'd1;
      if (pay_left == 0) begin
        go_idle();
        expect_field({56'd0, b}, 1'b1, 1'b1, ERR_OK);
      end else begin
        expect_field({56'd0, b}, 1'b1, 1'b0, ERR_OK);
      end
      return;
    end

    // big-endian fixed width
    if (fld_kind <= KIND_UINT32) begin
      acc      = {acc[55:0], b};
      byte_idx = byte_idx + 4'd1;
      need = (fld_kind == KIND_INT8) ? 1 : (fld_kind == KIND_INT16) ? 2 :
             (fld_kind == KIND_INT64) ? 8 : 4;
      if (byte_idx < need)
        return;
      case (fld_kind)
        KIND_INT8:   n = {{56{acc[7]}}, acc[7:0]};
        KIND_INT16:  n = {{48{acc[15]}}, acc[15:0]};
        KIND_INT32:  n = {{32{acc[31]}}, acc[31:0]};
        KIND_UINT32: n = {32'd0, acc[31:0]};
        default:     n = acc;
      endcase
      go_idle();
      expect_field(n, 1'b0, 1'b1, ERR_OK);
      return;
    end

    // LEB128, little-endian 7-bit groups; groups past bit 63 are lost
    if (fld_kind <= KIND_CSTRING) begin
      sh = VAR_GROUP * byte_idx;
      if (sh < 64)
        acc = acc | ({56'd0, b & DATA_MASK} << sh);
      byte_idx = byte_idx + 4'd1;
      if ((b & CONT_BIT) != 0) begin
        if (byte_idx >= MAX_VARINT_BYTES) begin
          go_idle();
          expect_field('0, 1'b0, 1'b1, ERR_VAR_LONG);
        end
        return;
      end
      n = acc;
      if (fld_kind == KIND_CSTRING) begin
        // wire carries length plus one; zero is illegal
        len      = n[31:0];
        acc      = '0;
        byte_idx = '0;
        if (len == 0) begin
          go_idle();
          expect_field('0, 1'b0, 1'b1, ERR_CLEN_ZERO);
        end else begin
          open_string(len - 32'd1);
        end
        return;
      end
      case (fld_kind)
        KIND_UVARINT: n = {32'd0, n[31:0]};
        KIND_VARINT: begin
          n = zigzag_decode(n);
          n = {{32{n[31]}}, n[31:0]};
        end
        KIND_VARLONG: n = zigzag_decode(n);
        default: ;
      endcase
      go_idle();
      expect_field(n, 1'b0, 1'b1, ERR_OK);
      return;
    end

    // nullable string: int16 length, negative means empty
    if (fld_kind == KIND_NSTRING) begin
      acc      = {acc[55:0], b};
      byte_idx = byte_idx + 4'd1;
      if (byte_idx < 2)
        return;
      len      = {16'd0, acc[15:0]};
      acc      = '0;
      byte_idx = '0;
      if (len[15])
        len = '0;
      open_string(len);
      return;
    end

    // tagged-field byte: anything but zero is flagged, byte echoed
    go_idle();
    if (b != ZERO_BYTE)
      expect_field({56'd0, b}, 1'b0, 1'b1, ERR_TAG_SET);
    else
      expect_field('0, 1'b0, 1'b1, ERR_OK);
  endfunction

  // --------------------------------------------------------------------------
  // Checker: every result transaction against the oldest expectation.
  // --------------------------------------------------------------------------
  function automatic void note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : check_fields
    result_t want;
    if (!rst && field_ch.valid && field_ch.ready) begin
      if (expected_fields.size() == 0) begin
        note_mismatch($sformatf("unexpected result value=%h pay=%b last=%b err=%0d",
                                field_ch.value, field_ch.is_payload, field_ch.last,
                                field_ch.error_code));
      end else begin
        want = expected_fields.pop_front();
        if (field_ch.value !== want.value)
          note_mismatch($sformatf("value exp %h got %h", want.value, field_ch.value));
        if (field_ch.is_payload !== want.is_payload)
          note_mismatch($sformatf("is_payload exp %b got %b (value %h)",
                                  want.is_payload, field_ch.is_payload, want.value));
        if (field_ch.last !== want.last)
          note_mismatch($sformatf("last exp %b got %b (value %h)",
                                  want.last, field_ch.last, want.value));
        if (field_ch.error_code !== want.error_code)
          note_mismatch($sformatf("error_code exp %0d got %0d (value %h)",
                                  want.error_code, field_ch.error_code, want.value));
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk)
    field_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // hang detection: counts cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (field_ch.valid && field_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Send one wire byte, with random gaps before it; predict at acceptance.
  task automatic send_byte(input logic [7:0] b, input logic [3:0] act);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.action  <= act;
    @(posedge clk);
    while (!byte_ch.ready)
      @(posedge clk);
    decode_byte(b, act);
    bytes_sent++;
  endtask

  // action only matters on a field's first byte; later bytes carry noise
  function automatic logic [3:0] next_action(input logic [3:0] kind, input bit first);
    return first ? kind : 4'($urandom_range(15));
  endfunction

  // random byte, with the boundary patterns weighted up
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return ZERO_BYTE;
      1: return DATA_MASK;
      2: return CONT_BIT;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // 64-bit value with a random number of significant bits
  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    v = {32'($urandom), 32'($urandom)};
    return v >> $urandom_range(64);
  endfunction

  // directed field: n bytes, taken from the low end of seq, first byte on top
  task automatic send_seq(input logic [3:0] kind, input int n, input logic [79:0] seq);
    int i;
    for (i = 0; i < n; i++)
      send_byte(seq[8*(n-1-i) +: 8], next_action(kind, i == 0));
  endtask

  // LEB128 encode; pad adds redundant zero groups (non-minimal form)
  task automatic send_leb128(input logic [3:0] kind, input logic [63:0] v, input int pad);
    logic [63:0] rest;
    logic [7:0]  b;
    int          pads;
    bit          more;
    bit          first;
    rest  = v;
    pads  = pad;
    first = 1'b1;
    do begin
      b    = {1'b0, rest[6:0]};
      rest = rest >> 7;
      more = (rest != 0) || (pads > 0);
      if (rest == 0 && pads > 0)
        pads--;
      if (more)
        b = b | CONT_BIT;
      send_byte(b, next_action(kind, first));
      first = 1'b0;
    end while (more);
  endtask

  task automatic send_random_varint(input logic [3:0] kind);
    int pick;
    int n;
    int i;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 60) begin
      send_leb128(kind, rand_wide(), ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0);
    end else if (pick < 85) begin
      // raw groups: junk in high groups, up to the byte limit
      n = $urandom_range(1, MAX_VARINT_BYTES);
      for (i = 0; i < n; i++) begin
        b = rand_byte();
        b = (i < n - 1) ? (b | CONT_BIT) : (b & DATA_MASK);
        send_byte(b, next_action(kind, i == 0));
      end
    end else begin
      // never terminates: must trip the length limit
      for (i = 0; i < MAX_VARINT_BYTES; i++)
        send_byte(rand_byte() | CONT_BIT, next_action(kind, i == 0));
    end
  endtask

  // One whole field of random type and content; counted excludes ignored bytes.
  task automatic send_random_field(output int counted);
    int pick;
    int n;
    int i;
    int start;
    int pad;
    logic [3:0]  kind;
    logic [63:0] v;
    logic [15:0] slen;
    start = bytes_sent;
    pick  = $urandom_range(99);
    if (pick < 4) begin
      // unused action code while idle: byte swallowed, no result
      kind = 4'(KIND_TAGGED + $urandom_range(1, 4));
      send_byte(rand_byte(), kind);
      counted = 0;
      return;
    end
    kind = 4'($urandom_range(KIND_TAGGED));
    case (kind)
      KIND_INT8, KIND_INT16, KIND_INT32, KIND_INT64, KIND_UINT32: begin
        n = (kind == KIND_INT8) ? 1 : (kind == KIND_INT16) ? 2 :
            (kind == KIND_INT64) ? 8 : 4;
        for (i = 0; i < n; i++)
          send_byte(rand_byte(), next_action(kind, i == 0));
      end
      KIND_UVARINT, KIND_VARINT, KIND_UVARLONG, KIND_VARLONG:
        send_random_varint(kind);
      KIND_CSTRING: begin
        // n is the wire length (payload plus one)
        pick = $urandom_range(99);
        if (pick < 5)       n = 0;
        else if (pick < 20) n = 1;
        else if (pick < 90) n = $urandom_range(2, 12);
        else                n = $urandom_range(13, 40);
        v   = 64'(n);
        pad = 0;
        if ($urandom_range(9) == 0)
          v[63:32] = $urandom;   // upper bits are dropped by the 32-bit length
        else if ($urandom_range(7) == 0)
          pad = $urandom_range(1, 3);
        send_leb128(kind, v, pad);
        for (i = 1; i < n; i++)
          send_byte(rand_byte(), next_action(kind, 1'b0));
      end
      KIND_NSTRING: begin
        pick = $urandom_range(99);
        if (pick < 15)      slen = 16'($urandom_range(16'hFFFF, 16'h8000));
        else if (pick < 25) slen = '0;
        else if (pick < 97) slen = 16'($urandom_range(1, 20));
        else                slen = 16'($urandom_range(100, 300));
        send_byte(slen[15:8], kind);
        send_byte(slen[7:0], next_action(kind, 1'b0));
        if (!slen[15])
          for (i = 0; i < slen; i++)
            send_byte(rand_byte(), next_action(kind, 1'b0));
      end
      default:
        send_byte(($urandom_range(9) < 6) ? ZERO_BYTE : rand_byte(), kind);
    endcase
    counted = bytes_sent - start;
  endtask

  // sender holds off until the decoder has delivered everything owed
  task automatic wait_for_results();
    byte_ch.valid <= 1'b0;
    do
      @(posedge clk);
    while (expected_fields.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_fixed_width();
    send_seq(KIND_INT8,   1, 80'h80);                  // most negative int8
    send_seq(KIND_INT16,  2, 80'h7FFF);                // most positive int16
    send_seq(KIND_INT32,  4, 80'h8000_0000);           // sign reaches bit 63
    send_seq(KIND_INT64,  8, 80'hFFFF_FFFF_FFFF_FFFF);
    send_seq(KIND_UINT32, 4, 80'hFFFF_FFFF);           // no sign extension
  endtask

  task automatic test_varints();
    send_seq(KIND_UVARINT,  2, 80'h8001);              // 128, second group
    send_seq(KIND_VARINT,   1, 80'h01);                // zigzag -1
    send_seq(KIND_UVARLONG, 1, 80'h7F);
    // continuation still set at the byte limit
    send_seq(KIND_VARLONG, MAX_VARINT_BYTES, {MAX_VARINT_BYTES{8'hFF}});
  endtask

  task automatic test_strings();
    send_seq(KIND_CSTRING, 1, 80'h00);                 // compact length zero
    send_seq(KIND_CSTRING, 1, 80'h01);                 // compact empty string
    send_seq(KIND_CSTRING, 3, 80'h03_61_62);
    send_seq(KIND_NSTRING, 2, 80'hFFFF);               // negative: empty
    send_seq(KIND_NSTRING, 2, 80'h0000);               // zero: empty
    send_seq(KIND_NSTRING, 3, 80'h0001_7A);
  endtask

  task automatic test_tagged_and_unused();
    send_seq(KIND_TAGGED, 1, 80'h00);
    send_seq(KIND_TAGGED, 1, 80'h5A);                  // nonzero tag flagged
    send_byte(8'hFF, KIND_TAGGED + 4'd4);              // unused code, ignored
    send_seq(KIND_INT8, 1, 80'h7F);                    // decoder still idle after it
    wait_for_results();
  endtask

  task automatic test_random_fields(input int idle_pct, input int stall_pct, input int target);
    int counted;
    int total;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    total = 0;
    while (total < target) begin
      send_random_field(counted);
      total += counted;
    end
    wait_for_results();
  endtask

  initial begin
    rst              = 1'b1;
    byte_ch.valid    = 1'b0;
    byte_ch.in_byte  = '0;
    byte_ch.action   = KIND_INT8;
    field_ch.ready   = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    bytes_sent       = 0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_fixed_width();
    test_varints();
    test_strings();
    test_tagged_and_unused();

    test_random_fields(0,  0,  PHASE_BYTES);
    test_random_fields(75, 0,  PHASE_BYTES);
    test_random_fields(0,  75, PHASE_BYTES);
    test_random_fields(27, 27, PHASE_BYTES);
    test_random_fields(0,  0,  PHASE_BYTES);

    // generous margin for stray results
    repeat (8) @(posedge clk);
    if (expected_fields.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_fields.size()));

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
